/* design/ccl_pkg.sv */
package ccl_pkg;

  // fixed field widths
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // result kinds loaded into the output register
  typedef enum logic [1:0] {
    RES_MISS,
    RES_HIT,
    RES_INVALID,
    RES_FULL
  } res_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_APPEND,
    S_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic capture;
    logic shift_wr;
    logic append;
    logic dec;
    logic load;
    res_e res;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    action_e act;
    logic    handle_zero;
    logic    cnt_zero;
    logic    full;
    logic    match;
    logic    last;
    logic    rd_valid;
    logic    idx_end;
    logic    out_free;
  } sts_t;

endpackage

/* design/ccl_ram.sv */
module ccl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ccl_datapath.sv */
module ccl_datapath import ccl_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [ACT_W-1:0]    action_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [HANDLE_W-1:0] handle_in_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CAP_W-1:0]    cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STAT_W-1:0]   status_o,
  output logic                hit_o,
  output logic [HANDLE_W-1:0] handle_out_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int ENT_W = KEY_W + HANDLE_W;

  logic [CAP_W-1:0]    cap_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    ridx_q;
  logic                rvalid_q;
  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [HANDLE_W-1:0] found_q;
  logic                out_valid_q;
  logic [STAT_W-1:0]   status_q;
  logic                hit_q;
  logic [HANDLE_W-1:0] hout_q;

  logic                rd_issue;
  logic [CNT_W-1:0]    ridx_nxt, ridx_prev;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ENT_W-1:0]    ram_wdata, ram_rdata;
  logic [KEY_W-1:0]    rd_key;
  logic [HANDLE_W-1:0] rd_handle;

  // configuration register; write it only while idle, the block itself does not enforce this
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // entry store, key in the upper half
  ccl_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (rd_issue),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd_key    = ram_rdata[ENT_W-1:HANDLE_W];
  assign rd_handle = ram_rdata[HANDLE_W-1:0];
  assign ridx_nxt  = ridx_q + CNT_W'(1);
  assign ridx_prev = ridx_q - CNT_W'(1);

  // scan pointer issues one read per cycle over the used entries
  assign rd_issue = cmd_i.scan && (idx_q < count_q);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start) begin
      idx_d = '0;
    end else if (rd_issue) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  // write port: append at the end or move an entry down by one
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ridx_prev[AW-1:0];
    ram_wdata = ram_rdata;
    if (cmd_i.append) begin
      ram_we    = 1'b1;
      ram_waddr = count_q[AW-1:0];
      ram_wdata = {key_q, handle_q};
    end else if (cmd_i.shift_wr && rvalid_q) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.append) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      idx_q    <= idx_d;
      rvalid_q <= rd_issue;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      ridx_q <= idx_q;
    end
    if (cmd_i.start) begin
      key_q    <= key_i;
      handle_q <= handle_in_i;
    end
    if (cmd_i.capture) begin
      found_q <= rd_handle;
    end
    if (cmd_i.load) begin
      case (cmd_i.res)
        RES_HIT: begin
          status_q <= ST_OK;
          hit_q    <= 1'b1;
          hout_q   <= found_q;
        end
        RES_INVALID: begin
          status_q <= ST_INVALID;
          hit_q    <= 1'b0;
          hout_q   <= '0;
        end
        RES_FULL: begin
          status_q <= ST_FULL;
          hit_q    <= 1'b0;
          hout_q   <= '0;
        end
        default: begin
          status_q <= ST_OK;
          hit_q    <= 1'b0;
          hout_q   <= '0;
        end
      endcase
    end
  end

  // status back to the controller
  assign sts_o.act         = action_e'(action_i);
  assign sts_o.handle_zero = (handle_in_i == '0);
  assign sts_o.cnt_zero    = (count_q == '0);
  assign sts_o.full        = (CW'(count_q) >= CW'(cap_q)) || (count_q == CNT_W'(DEPTH));
  assign sts_o.match       = rvalid_q && (rd_key == key_q);
  assign sts_o.last        = rvalid_q && (ridx_nxt == count_q);
  assign sts_o.rd_valid    = rvalid_q;
  assign sts_o.idx_end     = (idx_q >= count_q);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign hit_o        = hit_q;
  assign handle_out_o = hout_q;

endmodule

/* design/ccl_ctrl.sv */
module ccl_ctrl import ccl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e  state_q, state_d;
  action_e act_q, act_d;
  res_e    res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= ACT_LOOKUP;
      res_q   <= RES_MISS;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      res_q   <= res_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.res = res_q;
    unique case (state_q)
      // decode the accepted item, early outcomes go straight to finish
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          act_d       = sts_i.act;
          unique case (sts_i.act) inside
            ACT_LOOKUP, ACT_REMOVE: begin
              if (sts_i.cnt_zero) begin
                res_d   = RES_MISS;
                state_d = S_FINISH;
              end else begin
                state_d = S_SEARCH;
              end
            end
            ACT_INSERT: begin
              if (sts_i.handle_zero) begin
                res_d   = RES_INVALID;
                state_d = S_FINISH;
              end else if (sts_i.full) begin
                res_d   = RES_FULL;
                state_d = S_FINISH;
              end else if (sts_i.cnt_zero) begin
                state_d = S_APPEND;
              end else begin
                state_d = S_SEARCH;
              end
            end
            default: begin
              res_d   = RES_INVALID;
              state_d = S_FINISH;
            end
          endcase
        end
      end
      // one compare per cycle, stop at the first match
      S_SEARCH: begin
        cmd_o.scan = 1'b1;
        if (sts_i.match) begin
          cmd_o.capture = 1'b1;
          res_d         = RES_HIT;
          state_d       = (act_q == ACT_REMOVE) ? S_SHIFT : S_FINISH;
        end else if (sts_i.last) begin
          res_d   = RES_MISS;
          state_d = (act_q == ACT_INSERT) ? S_APPEND : S_FINISH;
        end
      end
      // move later entries down until the read pipe drains
      S_SHIFT: begin
        cmd_o.scan     = 1'b1;
        cmd_o.shift_wr = 1'b1;
        if (!sts_i.rd_valid && sts_i.idx_end) begin
          cmd_o.dec = 1'b1;
          state_d   = S_FINISH;
        end
      end
      S_APPEND: begin
        cmd_o.append = 1'b1;
        res_d        = RES_MISS;
        state_d      = S_FINISH;
      end
      // wait for the output register
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* design/compiled_code_lookup_table.sv */
// channel   direction  handshake               payload
// in        input      in_valid_i / in_stall_o  action_i, key_i, handle_in_i
// out       output     out_valid_o / out_stall_i status_o, hit_o, handle_out_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (capacity)
//
// one item at a time: a rejected insert or unused action goes from decode
// straight to finish; the single read port of the entry store visits one
// entry per cycle during search and during the compaction after a remove.
// reset empties the table and sets capacity to 16; no clearing pass.
// a stalled result holds in the output register while the next item runs.
module compiled_code_lookup_table import ccl_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ACT_W-1:0]    action_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [HANDLE_W-1:0] handle_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STAT_W-1:0]   status_o,
  output logic                hit_o,
  output logic [HANDLE_W-1:0] handle_out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CAP_W-1:0]    cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  ccl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // table storage, counters and result register
  ccl_datapath #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (action_i),
    .key_i       (key_i),
    .handle_in_i (handle_in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .hit_o       (hit_o),
    .handle_out_o(handle_out_o)
  );

endmodule

/* design/ccl_checker.sv */
module ccl_checker import ccl_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic [ACT_W-1:0]    action_i,
  input logic [KEY_W-1:0]    key_i,
  input logic [HANDLE_W-1:0] handle_in_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [STAT_W-1:0]   status_o,
  input logic                hit_o,
  input logic [HANDLE_W-1:0] handle_out_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [CAP_W-1:0]    cfg_data_i
);

  // the block is busy in the cycle after it accepts an item
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(status_o) && $stable(hit_o) && $stable(handle_out_o))
    else $error("result changed while stalled");

  // error results carry no hit and no handle
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> !hit_o && (handle_out_o == '0))
    else $error("error result with hit or handle");

  // stored handles are never zero
  a_hit_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> (handle_out_o != '0) && (status_o == ST_OK))
    else $error("hit with zero handle");

endmodule

bind compiled_code_lookup_table ccl_checker u_ccl_checker (.*);
